[design/lcb_pkg.sv]
package lcb_pkg;

   // field widths
   localparam int ACT_W  = 3;
   localparam int NODE_W = 10;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 11;
   localparam int WGT_W  = 34;

   // accumulator and divisor widths of the Q4.28 converter
   localparam int ACC_W  = 80;
   localparam int DIV_W  = 66;

   // action codes
   localparam logic [ACT_W-1:0] ACT_INIT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_MOVE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_GAIN = 3'd2;
   localparam logic [ACT_W-1:0] ACT_LOSS = 3'd3;
   localparam logic [ACT_W-1:0] ACT_MOD  = 3'd4;

   // one community row of the table
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [WGT_W-1:0] tot;
      logic [WGT_W-1:0] inn;
   } row_type;

endpackage

[design/lcb_q428.sv]
module lcb_q428 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lcb_pkg::ACC_W-1:0] plus_sum,
   input  logic [lcb_pkg::ACC_W-1:0] minus_sum,
   input  logic [lcb_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [31:0]               value
);

   localparam logic [2:0] Q_IDLE = 3'd0;
   localparam logic [2:0] Q_SAT  = 3'd1;
   localparam logic [2:0] Q_DIV  = 3'd2;
   localparam logic [2:0] Q_RND  = 3'd3;
   localparam logic [2:0] Q_FIN  = 3'd4;

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   logic [2:0]                qst_ff, qst_in;
   logic                      neg_ff, neg_in;
   logic [lcb_pkg::ACC_W-1:0] mag_ff, mag_in;
   logic [lcb_pkg::DIV_W-1:0] dv_ff, dv_in;
   logic [lcb_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [31:0]               nb_ff, nb_in;
   logic [31:0]               quo_ff, quo_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [32:0]               qr_ff, qr_in;
   logic                      done_ff, done_in;
   logic [31:0]               value_ff, value_in;
   logic [lcb_pkg::DIV_W:0]   trial;
   logic [32:0]               qc;

   assign done  = done_ff;
   assign value = value_ff;

   // sign and magnitude, saturation test, one quotient bit a cycle, rounding
   always_comb begin
      qst_in   = qst_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      dv_in    = dv_ff;
      rem_in   = rem_ff;
      nb_in    = nb_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      qr_in    = qr_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      trial    = {rem_ff, nb_ff[31]};
      qc       = (qr_ff > 33'h0_8000_0000) ? 33'h0_8000_0000 : qr_ff;
      case (qst_ff)
         Q_IDLE: begin
            if (start) begin
               neg_in = plus_sum < minus_sum;
               mag_in = (plus_sum < minus_sum) ? minus_sum - plus_sum : plus_sum - minus_sum;
               dv_in  = divisor;
               qst_in = Q_SAT;
            end
         end
         Q_SAT: begin
            if (mag_ff >= (lcb_pkg::ACC_W'(dv_ff) << 4)) begin
               value_in = neg_ff ? Q_MIN : Q_MAX;
               done_in  = 1'b1;
               qst_in   = Q_IDLE;
            end else begin
               rem_in = lcb_pkg::DIV_W'(mag_ff >> 4);
               nb_in  = {mag_ff[3:0], 28'd0};
               quo_in = '0;
               cnt_in = '0;
               qst_in = Q_DIV;
            end
         end
         Q_DIV: begin
            if (trial >= {1'b0, dv_ff}) begin
               rem_in = lcb_pkg::DIV_W'(trial - {1'b0, dv_ff});
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = lcb_pkg::DIV_W'(trial);
               quo_in = {quo_ff[30:0], 1'b0};
            end
            nb_in  = {nb_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               qst_in = Q_RND;
            end
         end
         Q_RND: begin
            qr_in  = {1'b0, quo_ff} + (({rem_ff, 1'b0} >= {1'b0, dv_ff}) ? 33'd1 : 33'd0);
            qst_in = Q_FIN;
         end
         Q_FIN: begin
            if (!neg_ff) begin
               value_in = (qr_ff > {1'b0, Q_MAX}) ? Q_MAX : qr_ff[31:0];
            end else begin
               value_in = ~qc[31:0] + 32'd1;
            end
            done_in = 1'b1;
            qst_in  = Q_IDLE;
         end
         default: begin
            qst_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qst_ff  <= Q_IDLE;
         done_ff <= 1'b0;
      end else begin
         qst_ff  <= qst_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      dv_ff    <= dv_in;
      rem_ff   <= rem_in;
      nb_ff    <= nb_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      qr_ff    <= qr_in;
      value_ff <= value_in;
   end

endmodule

[design/louvain_community_bookkeeper.sv]
// Louvain community bookkeeper: keeps a label per node and, per community, member count,
// total linked weight and inner weight, and answers gain, loss and modularity queries in
// saturated signed Q4.28. One word is worked on at a time; req_stall is high while busy.
// After reset a clearing pass writes every community row, during which no word is taken
// (csr writes are). Gain and loss form 3 or 4 products through one shared 34x17 multiplier,
// then pass through the Q4.28 converter, which uses restoring division unless the answer
// saturates. Modularity reads every community row through the single table port.
module louvain_community_bookkeeper #(
   parameter int NODES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lcb_pkg::ACT_W-1:0]   req_action,
   input  logic [lcb_pkg::NODE_W-1:0]  req_node,
   input  logic [lcb_pkg::NODE_W-1:0]  req_target,
   input  logic [lcb_pkg::WORD_W-1:0]  req_node_degree,
   input  logic [lcb_pkg::WORD_W-1:0]  req_self_loop,
   input  logic [lcb_pkg::WORD_W-1:0]  req_old_shared,
   input  logic [lcb_pkg::WORD_W-1:0]  req_new_shared,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lcb_pkg::NODE_W-1:0]  rsp_community,
   output logic signed [31:0]          rsp_value,
   output logic                        rsp_valid_res,
   output logic                        rsp_changed,
   input  logic                        csr_wr_en,
   input  logic [lcb_pkg::WORD_W-1:0]  csr_wr_data
);

   localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [IW-1:0] LAST = IW'(NODES - 1);
   localparam int HALF_W = 17;
   localparam int PP_W   = lcb_pkg::WGT_W + HALF_W;
   localparam int SQ_W   = 64;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_START = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_ROW   = 4'd4;
   localparam logic [3:0] S_ROWD  = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_CONV  = 4'd7;
   localparam logic [3:0] S_WAIT  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic [1:0] DST_P = 2'd0;
   localparam logic [1:0] DST_M = 2'd1;
   localparam logic [1:0] DST_D = 2'd2;

   localparam logic [lcb_pkg::WGT_W-1:0] WGT_MAX = '1;
   localparam logic [lcb_pkg::CNT_W-1:0] CNT_MAX = '1;

   // tables
   lcb_pkg::row_type           row_mem [NODES];
   logic [lcb_pkg::NODE_W-1:0] lbl_mem [NODES];

   logic [3:0]                 state_ff, state_in;
   logic [IW-1:0]              rowa_ff, rowa_in;
   logic [1:0]                 mstep_ff, mstep_in;
   logic [1:0]                 ph_ff, ph_in;
   logic                       leave_ff, leave_in;
   logic [lcb_pkg::WORD_W-1:0] tw_ff;

   logic [lcb_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [lcb_pkg::NODE_W-1:0] node_ff, node_in;
   logic [lcb_pkg::NODE_W-1:0] tgt_ff, tgt_in;
   logic [lcb_pkg::WORD_W-1:0] deg_ff, deg_in;
   logic [lcb_pkg::WORD_W-1:0] loop_ff, loop_in;
   logic [lcb_pkg::WORD_W-1:0] olds_ff, olds_in;
   logic [lcb_pkg::WORD_W-1:0] news_ff, news_in;

   logic [lcb_pkg::NODE_W-1:0] comm_ff, comm_in;
   logic [31:0]                val_ff, val_in;
   logic                       vres_ff, vres_in;
   logic                       chg_ff, chg_in;

   logic [lcb_pkg::WGT_W-1:0]  tot_ff, tot_in;
   logic [lcb_pkg::WGT_W-1:0]  inn_ff, inn_in;
   logic [lcb_pkg::ACC_W-1:0]  accp_ff, accp_in;
   logic [lcb_pkg::ACC_W-1:0]  accm_ff, accm_in;
   logic [SQ_W-1:0]            accd_ff, accd_in;
   logic [PP_W-1:0]            pp_ff, pp_in;

   lcb_pkg::row_type           row_rd_ff;
   lcb_pkg::row_type           row_wd;
   logic                       row_we;
   logic [lcb_pkg::NODE_W-1:0] lbl_rd_ff;
   logic [lcb_pkg::NODE_W-1:0] lbl_wd;
   logic                       lbl_we;
   logic [IW-1:0]              lbl_addr;

   logic                       rsp_valid_ff;
   logic [lcb_pkg::NODE_W-1:0] rsp_comm_ff;
   logic [31:0]                rsp_val_ff;
   logic                       rsp_vres_ff;
   logic                       rsp_chg_ff;
   logic                       rsp_load;

   logic [lcb_pkg::WGT_W-1:0]  opa, opb;
   logic [1:0]                 dst;
   logic [1:0]                 mul_last;
   logic [HALF_W-1:0]          half;
   logic [lcb_pkg::ACC_W-1:0]  pp_term;
   logic [lcb_pkg::WGT_W-1:0]  w34, w2, deg34, olds34, news34, loop34;
   logic                       node_ok, tgt_ok, lbl_ok;
   logic [lcb_pkg::DIV_W-1:0]  divisor;
   logic                       q_start, q_done;
   logic [31:0]                q_value;

   // add to a row with saturation
   function automatic lcb_pkg::row_type row_join(lcb_pkg::row_type r,
                                                 logic [lcb_pkg::WGT_W-1:0] dg,
                                                 logic [lcb_pkg::WGT_W-1:0] add);
      lcb_pkg::row_type      o;
      logic [lcb_pkg::WGT_W:0] st, si;
      st    = {1'b0, r.tot} + {1'b0, dg};
      si    = {1'b0, r.inn} + {1'b0, add};
      o.cnt = (r.cnt == CNT_MAX) ? r.cnt : r.cnt + 1'b1;
      o.tot = st[lcb_pkg::WGT_W] ? WGT_MAX : st[lcb_pkg::WGT_W-1:0];
      o.inn = si[lcb_pkg::WGT_W] ? WGT_MAX : si[lcb_pkg::WGT_W-1:0];
      return o;
   endfunction

   // take from a row, stopping at zero
   function automatic lcb_pkg::row_type row_leave(lcb_pkg::row_type r,
                                                  logic [lcb_pkg::WGT_W-1:0] dg,
                                                  logic [lcb_pkg::WGT_W-1:0] sub);
      lcb_pkg::row_type o;
      o.cnt = (r.cnt == '0) ? r.cnt : r.cnt - 1'b1;
      o.tot = (r.tot > dg) ? r.tot - dg : '0;
      o.inn = (r.inn > sub) ? r.inn - sub : '0;
      return o;
   endfunction

   assign w34     = {2'b00, tw_ff};
   assign w2      = {1'b0, tw_ff, 1'b0};
   assign deg34   = {2'b00, deg_ff};
   assign olds34  = {2'b00, olds_ff};
   assign news34  = {2'b00, news_ff};
   assign loop34  = {2'b00, loop_ff};
   assign node_ok = {22'd0, node_ff} < 32'(NODES);
   assign tgt_ok  = {22'd0, tgt_ff} < 32'(NODES);
   assign lbl_ok  = {22'd0, lbl_rd_ff} < 32'(NODES);
   assign lbl_addr = IW'(node_ff);
   assign mul_last = (act_ff == lcb_pkg::ACT_LOSS) ? 2'd3 : 2'd2;
   assign divisor = (act_ff == lcb_pkg::ACT_MOD) ? lcb_pkg::DIV_W'({accd_ff, 2'b00})
                                                 : lcb_pkg::DIV_W'({accd_ff, 1'b0});

   // product program: step 0 is W*W for the divisor, then the numerator terms
   always_comb begin
      opa = w34;
      opb = w34;
      dst = DST_D;
      if (mstep_ff != 2'd0) begin
         case (act_ff)
            lcb_pkg::ACT_GAIN: begin
               if (mstep_ff == 2'd1) begin
                  opa = w2;     opb = news34; dst = DST_P;
               end else begin
                  opa = tot_ff; opb = deg34;  dst = DST_M;
               end
            end
            lcb_pkg::ACT_LOSS: begin
               case (mstep_ff)
                  2'd1: begin
                     opa = tot_ff; opb = deg34; dst = DST_P;
                  end
                  2'd2: begin
                     opa = w2;    opb = olds34; dst = DST_M;
                  end
                  default: begin
                     opa = deg34; opb = deg34;  dst = DST_M;
                  end
               endcase
            end
            lcb_pkg::ACT_MOD: begin
               if (mstep_ff == 2'd1) begin
                  opa = inn_ff; opb = w2;     dst = DST_P;
               end else begin
                  opa = tot_ff; opb = tot_ff; dst = DST_M;
               end
            end
            default: begin
               dst = DST_D;
            end
         endcase
      end
   end

   // shared 34x17 multiplier, low half then high half
   assign half    = (ph_ff == 2'd0) ? opb[HALF_W-1:0] : opb[lcb_pkg::WGT_W-1:HALF_W];
   assign pp_in   = {{HALF_W{1'b0}}, opa} * {{lcb_pkg::WGT_W{1'b0}}, half};
   assign pp_term = (ph_ff == 2'd2) ? (lcb_pkg::ACC_W'(pp_ff) << HALF_W)
                                    : lcb_pkg::ACC_W'(pp_ff);

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      rowa_in  = rowa_ff;
      mstep_in = mstep_ff;
      ph_in    = ph_ff;
      leave_in = leave_ff;
      act_in   = act_ff;
      node_in  = node_ff;
      tgt_in   = tgt_ff;
      deg_in   = deg_ff;
      loop_in  = loop_ff;
      olds_in  = olds_ff;
      news_in  = news_ff;
      comm_in  = comm_ff;
      val_in   = val_ff;
      vres_in  = vres_ff;
      chg_in   = chg_ff;
      tot_in   = tot_ff;
      inn_in   = inn_ff;
      accp_in  = accp_ff;
      accm_in  = accm_ff;
      accd_in  = accd_ff;
      row_we   = 1'b0;
      row_wd   = row_rd_ff;
      lbl_we   = 1'b0;
      lbl_wd   = tgt_ff;
      q_start  = 1'b0;
      case (state_ff)
         S_CLR: begin
            row_we  = 1'b1;
            row_wd  = '0;
            rowa_in = rowa_ff + IW'(1);
            if (rowa_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               node_in  = req_node;
               tgt_in   = req_target;
               deg_in   = req_node_degree;
               loop_in  = req_self_loop;
               olds_in  = req_old_shared;
               news_in  = req_new_shared;
               comm_in  = '0;
               val_in   = '0;
               vres_in  = 1'b1;
               chg_in   = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            accp_in  = '0;
            accm_in  = '0;
            accd_in  = '0;
            mstep_in = 2'd0;
            ph_in    = 2'd0;
            if (act_ff > lcb_pkg::ACT_MOD) begin
               vres_in  = 1'b0;
               state_in = S_DONE;
            end else if (act_ff == lcb_pkg::ACT_MOD) begin
               if (tw_ff == '0) begin
                  vres_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end else if (!node_ok || ((act_ff == lcb_pkg::ACT_MOVE ||
                                       act_ff == lcb_pkg::ACT_GAIN) && !tgt_ok)) begin
               state_in = S_DONE;
            end else if (act_ff == lcb_pkg::ACT_INIT) begin
               comm_in  = node_ff;
               rowa_in  = IW'(node_ff);
               state_in = S_ROW;
            end else begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            comm_in = lbl_rd_ff;
            case (act_ff)
               lcb_pkg::ACT_MOVE: begin
                  if (lbl_rd_ff == tgt_ff) begin
                     state_in = S_DONE;
                  end else begin
                     chg_in   = 1'b1;
                     comm_in  = tgt_ff;
                     leave_in = lbl_ok;
                     rowa_in  = lbl_ok ? IW'(lbl_rd_ff) : IW'(tgt_ff);
                     state_in = S_ROW;
                  end
               end
               lcb_pkg::ACT_GAIN: begin
                  if (tw_ff == '0) begin
                     vres_in  = 1'b0;
                     state_in = S_DONE;
                  end else if (!lbl_ok || lbl_rd_ff == tgt_ff) begin
                     state_in = S_DONE;
                  end else begin
                     rowa_in  = IW'(tgt_ff);
                     state_in = S_ROW;
                  end
               end
               lcb_pkg::ACT_LOSS: begin
                  if (tw_ff == '0) begin
                     vres_in  = 1'b0;
                     state_in = S_DONE;
                  end else if (!lbl_ok) begin
                     state_in = S_DONE;
                  end else begin
                     rowa_in  = IW'(lbl_rd_ff);
                     state_in = S_ROW;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_ROW: begin
            state_in = S_ROWD;
         end
         S_ROWD: begin
            case (act_ff)
               lcb_pkg::ACT_INIT: begin
                  row_we   = 1'b1;
                  row_wd   = row_join(row_rd_ff, deg34, loop34);
                  lbl_we   = 1'b1;
                  lbl_wd   = node_ff;
                  state_in = S_DONE;
               end
               lcb_pkg::ACT_MOVE: begin
                  row_we = 1'b1;
                  if (leave_ff) begin
                     row_wd   = row_leave(row_rd_ff, deg34, {olds34[32:0], 1'b0} + loop34);
                     leave_in = 1'b0;
                     rowa_in  = IW'(tgt_ff);
                     state_in = S_ROW;
                  end else begin
                     row_wd   = row_join(row_rd_ff, deg34, {news34[32:0], 1'b0} + loop34);
                     lbl_we   = 1'b1;
                     lbl_wd   = tgt_ff;
                     state_in = S_DONE;
                  end
               end
               lcb_pkg::ACT_MOD: begin
                  tot_in = row_rd_ff.tot;
                  inn_in = row_rd_ff.inn;
                  if (row_rd_ff.cnt != '0) begin
                     mstep_in = 2'd1;
                     ph_in    = 2'd0;
                     state_in = S_MUL;
                  end else if (rowa_ff == LAST) begin
                     state_in = S_CONV;
                  end else begin
                     rowa_in  = rowa_ff + IW'(1);
                     state_in = S_ROW;
                  end
               end
               default: begin
                  tot_in   = row_rd_ff.tot;
                  mstep_in = 2'd0;
                  ph_in    = 2'd0;
                  state_in = S_MUL;
               end
            endcase
         end
         S_MUL: begin
            // phase 0 forms the low partial product, 1 and 2 accumulate
            if (ph_ff != 2'd0) begin
               case (dst)
                  DST_P:   accp_in = accp_ff + pp_term;
                  DST_M:   accm_in = accm_ff + pp_term;
                  default: accd_in = accd_ff + SQ_W'(pp_term);
               endcase
            end
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in = 2'd0;
               if (act_ff == lcb_pkg::ACT_MOD) begin
                  if (mstep_ff == 2'd0) begin
                     rowa_in  = '0;
                     state_in = S_ROW;
                  end else if (mstep_ff == 2'd2) begin
                     if (rowa_ff == LAST) begin
                        state_in = S_CONV;
                     end else begin
                        rowa_in  = rowa_ff + IW'(1);
                        state_in = S_ROW;
                     end
                  end else begin
                     mstep_in = mstep_ff + 2'd1;
                  end
               end else if (mstep_ff == mul_last) begin
                  state_in = S_CONV;
               end else begin
                  mstep_in = mstep_ff + 2'd1;
               end
            end
         end
         S_CONV: begin
            q_start  = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (q_done) begin
               val_in   = q_value;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // table ports, read data registered
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[rowa_ff] <= row_wd;
      end
      row_rd_ff <= row_mem[rowa_ff];
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         lbl_mem[lbl_addr] <= lbl_wd;
      end
      lbl_rd_ff <= lbl_mem[lbl_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rowa_ff      <= '0;
         mstep_ff     <= 2'd0;
         ph_ff        <= 2'd0;
         leave_ff     <= 1'b0;
         tw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rowa_ff  <= rowa_in;
         mstep_ff <= mstep_in;
         ph_ff    <= ph_in;
         leave_ff <= leave_in;
         if (csr_wr_en) begin
            tw_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      node_ff <= node_in;
      tgt_ff  <= tgt_in;
      deg_ff  <= deg_in;
      loop_ff <= loop_in;
      olds_ff <= olds_in;
      news_ff <= news_in;
      comm_ff <= comm_in;
      val_ff  <= val_in;
      vres_ff <= vres_in;
      chg_ff  <= chg_in;
      tot_ff  <= tot_in;
      inn_ff  <= inn_in;
      accp_ff <= accp_in;
      accm_ff <= accm_in;
      accd_ff <= accd_in;
      pp_ff   <= pp_in;
      if (rsp_load) begin
         rsp_comm_ff <= comm_ff;
         rsp_val_ff  <= val_ff;
         rsp_vres_ff <= vres_ff;
         rsp_chg_ff  <= chg_ff;
      end
   end

   lcb_q428 u_q428 (
      .clock     (clock),
      .reset     (reset),
      .start     (q_start),
      .plus_sum  (accp_ff),
      .minus_sum (accm_ff),
      .divisor   (divisor),
      .done      (q_done),
      .value     (q_value)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_community = rsp_comm_ff;
   assign rsp_value     = rsp_val_ff;
   assign rsp_valid_res = rsp_vres_ff;
   assign rsp_changed   = rsp_chg_ff;

endmodule
